>>> src/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Types, register indexes and timing constants of the fault blink signature.
// ----------------------------------------------------------------------------
package fbs_pkg;

	localparam int TIME_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
	localparam int IDX_WIDTH = 3;

	localparam logic [TIME_WIDTH-1:0] ELAPSED_MAX = {TIME_WIDTH{1'b1}};

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_GROUP_PERIOD = 3'd0,
		REG_SHORT_PULSE  = 3'd1,
		REG_LONG_PULSE   = 3'd2,
		REG_PULSE_GAP    = 3'd3,
		REG_ACTIVE_LOW   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WAIT   = 3'd1,
		PH_P1_ON  = 3'd2,
		PH_P1_GAP = 3'd3,
		PH_P2_ON  = 3'd4,
		PH_P2_GAP = 3'd5,
		PH_P3_ON  = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] group_period;
		logic [CFG_WIDTH-1:0] short_pulse;
		logic [CFG_WIDTH-1:0] long_pulse;
		logic [CFG_WIDTH-1:0] pulse_gap;
		logic                 active_low;
	} cfg_t;

	typedef struct packed {
		logic wifi_ok;
		logic mqtt_ok;
		logic sensor_ok;
		logic heater_on;
	} tick_t;

	typedef struct packed {
		logic pin_level;
		logic pulse_active;
	} led_t;

endpackage

>>> src/fbs_cfg.sv
// ----------------------------------------------------------------------------
// fbs_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module fbs_cfg
	import fbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [IDX_WIDTH-1:0] wr_index,
	input  logic [CFG_WIDTH-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_period <= CFG_WIDTH'(5000);
			cfg_q.short_pulse  <= CFG_WIDTH'(150);
			cfg_q.long_pulse   <= CFG_WIDTH'(600);
			cfg_q.pulse_gap    <= CFG_WIDTH'(300);
			cfg_q.active_low   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GROUP_PERIOD: cfg_q.group_period <= wr_data;
				REG_SHORT_PULSE:  cfg_q.short_pulse  <= wr_data;
				REG_LONG_PULSE:   cfg_q.long_pulse   <= wr_data;
				REG_PULSE_GAP:    cfg_q.pulse_gap    <= wr_data;
				REG_ACTIVE_LOW:   cfg_q.active_low   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/fbs_core.sv
// ----------------------------------------------------------------------------
// fbs_core
// Phase sequencer: holds phase, elapsed count and last fault flag, and
// computes the LED result of the tick presented to it.
// ----------------------------------------------------------------------------
module fbs_core
	import fbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  tick_t tick,
	input  cfg_t  cfg,
	output led_t  led
);

	phase_t                phase_q, phase_d, phase_mid;
	logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_mid;
	logic                  fault_seen_q;
	logic                  fault, fault_change;
	logic [CFG_WIDTH-1:0]  pulse_dur;
	logic                  hit_group, hit_gap, hit_pulse;
	logic                  pulse;

	// A threshold above the counter range is clipped, so a saturated
	// counter always counts as having reached it.
	function automatic logic reached(input logic [TIME_WIDTH-1:0] el,
	                                 input logic [CFG_WIDTH-1:0] thr);
		reached = (CMP_WIDTH'(el) >= CMP_WIDTH'(thr)) || (el == ELAPSED_MAX);
	endfunction

	assign fault        = ~(tick.wifi_ok & tick.mqtt_ok & tick.sensor_ok);
	assign fault_change = (fault != fault_seen_q);

	always_comb begin
		elapsed_mid = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
		phase_mid   = phase_q;
		if (fault_change) begin
			elapsed_mid = '0;
			phase_mid   = fault ? PH_WAIT : PH_IDLE;
		end
	end

	always_comb begin
		case (phase_mid)
			PH_P1_ON: pulse_dur = tick.wifi_ok   ? cfg.short_pulse : cfg.long_pulse;
			PH_P2_ON: pulse_dur = tick.mqtt_ok   ? cfg.short_pulse : cfg.long_pulse;
			default:  pulse_dur = tick.sensor_ok ? cfg.short_pulse : cfg.long_pulse;
		endcase
	end

	assign hit_group = reached(elapsed_mid, cfg.group_period);
	assign hit_gap   = reached(elapsed_mid, cfg.pulse_gap);
	assign hit_pulse = reached(elapsed_mid, pulse_dur);

	// Next state.
	always_comb begin
		phase_d   = phase_mid;
		elapsed_d = elapsed_mid;
		unique case (phase_mid)
			PH_IDLE: ;
			PH_WAIT: if (hit_group) begin
				phase_d   = fault ? PH_P1_ON : PH_IDLE;
				elapsed_d = '0;
			end
			PH_P1_ON: if (hit_pulse) begin
				phase_d   = PH_P1_GAP;
				elapsed_d = '0;
			end
			PH_P1_GAP: if (hit_gap) begin
				phase_d   = PH_P2_ON;
				elapsed_d = '0;
			end
			PH_P2_ON: if (hit_pulse) begin
				phase_d   = PH_P2_GAP;
				elapsed_d = '0;
			end
			PH_P2_GAP: if (hit_gap) begin
				phase_d   = PH_P3_ON;
				elapsed_d = '0;
			end
			PH_P3_ON: if (hit_pulse) begin
				phase_d   = PH_DONE;
				elapsed_d = '0;
			end
			PH_DONE: begin
				phase_d   = PH_WAIT;
				elapsed_d = '0;
			end
			default: ;
		endcase
	end

	// Outputs.
	always_comb begin
		unique case (phase_mid)
			PH_WAIT:                        pulse = hit_group & fault;
			PH_P1_ON, PH_P2_ON, PH_P3_ON:   pulse = 1'b1;
			PH_P1_GAP, PH_P2_GAP:           pulse = hit_gap;
			default:                        pulse = 1'b0;
		endcase
	end

	assign led.pulse_active = pulse;
	assign led.pin_level    = tick.heater_on ^ pulse ^ cfg.active_low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			elapsed_q    <= '0;
			fault_seen_q <= 1'b1;
		end else if (advance) begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			fault_seen_q <= fault;
		end
	end

	a_pulse_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(!fault_change && (phase_q == PH_P1_ON || phase_q == PH_P2_ON ||
		 phase_q == PH_P3_ON)) |-> pulse)
		else $error("pulse phase without active pulse");

	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fault_change) |=> (elapsed_q == '0))
		else $error("fault change did not restart the elapsed count");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !fault_change && phase_q == PH_DONE) |=> (phase_q == PH_WAIT))
		else $error("done phase did not return to wait");

	a_idle_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(!fault_change && phase_q == PH_IDLE) |-> !pulse)
		else $error("pulse while idle");

endmodule

>>> src/fault_blink_signature.sv
// Pipeline: a tick request is registered in the input stage on acceptance
// and evaluated there; its LED result is loaded into the output register
// once the result stage is free, and is offered from that register.
// Throughput: one tick request per cycle while no result stalls; the phase
// compare and update run in one pass between the input and result registers.
// Reset: phase is WAIT with a fault assumed, the elapsed count is zero and
// the configuration registers take their defaults; both stages are empty.
// ----------------------------------------------------------------------------
// fault_blink_signature
// Status LED that blinks a three-pulse fault signature over a heater base.
// ----------------------------------------------------------------------------
module fault_blink_signature
	import fbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Tick request channel.
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick,
	// LED result channel.
	output logic                 led_valid,
	input  logic                 led_ready,
	output led_t                 led,
	// Configuration write port.
	input  logic                 wr_en,
	input  logic [IDX_WIDTH-1:0] wr_index,
	input  logic [CFG_WIDTH-1:0] wr_data
);

	cfg_t  cfg;
	tick_t tick_s1;
	logic  valid_s1;
	led_t  led_s2;
	logic  valid_s2;
	led_t  led_next;
	logic  s2_free;
	logic  advance;

	// The result stage can take a new result when it is empty or its
	// current result leaves this cycle. The input stage drains into it.
	assign s2_free    = !valid_s2 || led_ready;
	assign advance    = valid_s1 && s2_free;
	assign tick_ready = !valid_s1 || s2_free;

	fbs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// The sequencer state moves only when the registered tick is handed on,
	// so every request updates it exactly once.
	fbs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tick    (tick_s1),
		.cfg     (cfg),
		.led     (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick_ready) begin
				valid_s1 <= tick_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (tick_ready && tick_valid) begin
			tick_s1 <= tick;
		end
		if (advance) begin
			led_s2 <= led_next;
		end
	end

	assign led_valid = valid_s2;
	assign led       = led_s2;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> (valid_s1 && valid_s2 && !led_ready))
		else $error("tick request refused without a stalled result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated tick produced no result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !led_ready) |=> (valid_s2 && $stable(led_s2)))
		else $error("stalled result changed");

endmodule
